>>> design/rfbpfc_pkg.sv
// Shared types and codes for the RFB pixel format converter.
// Used by the cfg_regs, convert and top-level modules; depends on nothing.
package rfbpfc_pkg;

  // Configuration register indexes on the cfg_ write channel.
  typedef enum logic [2:0] {
    CFG_SOURCE_FORMAT  = 3'd0,
    CFG_OUT_MODE       = 3'd1,
    CFG_RED_WIDTH      = 3'd2,
    CFG_GREEN_WIDTH    = 3'd3,
    CFG_BLUE_WIDTH     = 3'd4,
    CFG_RED_POSITION   = 3'd5,
    CFG_GREEN_POSITION = 3'd6,
    CFG_BLUE_POSITION  = 3'd7
  } cfg_index_t;

  // Screen pixel formats.
  localparam logic [1:0] SRC_PALETTE  = 2'd0;
  localparam logic [1:0] SRC_RGB565   = 2'd1;
  localparam logic [1:0] SRC_XRGB8888 = 2'd2;

  // Client pixel layouts.
  localparam logic [2:0] MODE_ONE_BYTE     = 3'd0;
  localparam logic [2:0] MODE_TWO_NATIVE   = 3'd1;
  localparam logic [2:0] MODE_TWO_SWAPPED  = 3'd2;
  localparam logic [2:0] MODE_FOUR_NATIVE  = 3'd3;
  localparam logic [2:0] MODE_FOUR_SWAPPED = 3'd4;
  localparam logic [2:0] MODE_THREE_BYTES  = 3'd5;

  // Register contents after reset: xRGB8888 screen, 32-bit native client.
  localparam logic [1:0] SOURCE_FORMAT_RST  = SRC_XRGB8888;
  localparam logic [2:0] OUT_MODE_RST       = MODE_FOUR_NATIVE;
  localparam logic [3:0] WIDTH_RST          = 4'd8;
  localparam logic [4:0] RED_POSITION_RST   = 5'd16;
  localparam logic [4:0] GREEN_POSITION_RST = 5'd8;
  localparam logic [4:0] BLUE_POSITION_RST  = 5'd0;

  // Current client pixel format as one bundle.
  typedef struct packed {
    logic [1:0] source_format;
    logic [2:0] out_mode;
    logic [3:0] red_width;
    logic [3:0] green_width;
    logic [3:0] blue_width;
    logic [4:0] red_position;
    logic [4:0] green_position;
    logic [4:0] blue_position;
  } cfg_t;

endpackage

>>> design/rfbpfc_cfg_regs.sv
// Configuration register file of the RFB pixel format converter.
// Depends on rfbpfc_pkg for the register indexes, reset values and cfg_t.
module rfbpfc_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [2:0]          wr_index,
  input  logic [4:0]          wr_data,
  output rfbpfc_pkg::cfg_t    cfg
);

  rfbpfc_pkg::cfg_t cfg_r;
  rfbpfc_pkg::cfg_t cfg_nxt;

  // Decode the write beat onto one register.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (rfbpfc_pkg::cfg_index_t'(wr_index))
        rfbpfc_pkg::CFG_SOURCE_FORMAT:  cfg_nxt.source_format  = wr_data[1:0];
        rfbpfc_pkg::CFG_OUT_MODE:       cfg_nxt.out_mode       = wr_data[2:0];
        rfbpfc_pkg::CFG_RED_WIDTH:      cfg_nxt.red_width      = wr_data[3:0];
        rfbpfc_pkg::CFG_GREEN_WIDTH:    cfg_nxt.green_width    = wr_data[3:0];
        rfbpfc_pkg::CFG_BLUE_WIDTH:     cfg_nxt.blue_width     = wr_data[3:0];
        rfbpfc_pkg::CFG_RED_POSITION:   cfg_nxt.red_position   = wr_data;
        rfbpfc_pkg::CFG_GREEN_POSITION: cfg_nxt.green_position = wr_data;
        rfbpfc_pkg::CFG_BLUE_POSITION:  cfg_nxt.blue_position  = wr_data;
        default:                        cfg_nxt = cfg_r;
      endcase
    end
  end

  // Register state, reset to a 32-bit xRGB client format.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_format  <= rfbpfc_pkg::SOURCE_FORMAT_RST;
      cfg_r.out_mode       <= rfbpfc_pkg::OUT_MODE_RST;
      cfg_r.red_width      <= rfbpfc_pkg::WIDTH_RST;
      cfg_r.green_width    <= rfbpfc_pkg::WIDTH_RST;
      cfg_r.blue_width     <= rfbpfc_pkg::WIDTH_RST;
      cfg_r.red_position   <= rfbpfc_pkg::RED_POSITION_RST;
      cfg_r.green_position <= rfbpfc_pkg::GREEN_POSITION_RST;
      cfg_r.blue_position  <= rfbpfc_pkg::BLUE_POSITION_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/rfbpfc_palette.sv
// Colour palette memory of the RFB pixel format converter.
// One write port and one read port with registered read data; no package use.
module rfbpfc_palette #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [23:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [23:0]   rd_data
);

  logic [23:0] mem [DEPTH];
  logic [23:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no new read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/rfbpfc_convert.sv
// Combinational conversion of one screen pixel into client bytes.
// Depends on rfbpfc_pkg for cfg_t and the format and layout codes.
module rfbpfc_convert (
  input  rfbpfc_pkg::cfg_t cfg,
  input  logic [31:0]      source_pixel,
  input  logic [23:0]      palette_color,
  input  logic             palette_hit,
  output logic [31:0]      word,
  output logic [2:0]       byte_count
);

  // Keep the top bits of an 8-bit channel and move them to their position.
  function automatic logic [31:0] place_channel(input logic [7:0] c8,
                                                input logic [3:0] width,
                                                input logic [4:0] pos);
    logic [3:0] w;
    logic [3:0] sh;
    logic [7:0] v;
    w  = (width > 4'd8) ? 4'd8 : width;
    sh = 4'd8 - w;
    v  = c8 >> sh;
    return {24'd0, v} << pos;
  endfunction

  logic [2:0]  mode;
  logic [23:0] color;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [31:0] pix;
  logic        raw32;
  logic        raw16;

  // Unknown layouts fall back to four bytes native.
  assign mode = (cfg.out_mode > rfbpfc_pkg::MODE_THREE_BYTES) ?
                rfbpfc_pkg::MODE_FOUR_NATIVE : cfg.out_mode;

  // Same-endian cases that carry the screen pixel unchanged.
  assign raw32 = (cfg.source_format == rfbpfc_pkg::SRC_XRGB8888) &&
                 (mode == rfbpfc_pkg::MODE_FOUR_NATIVE);
  assign raw16 = (cfg.source_format == rfbpfc_pkg::SRC_RGB565) &&
                 (mode == rfbpfc_pkg::MODE_TWO_NATIVE) &&
                 (cfg.red_width == 4'd5) && (cfg.green_width == 4'd6) &&
                 (cfg.blue_width == 4'd5);

  // A palette index beyond the store reads as black.
  assign color = palette_hit ? palette_color : 24'd0;

  // Widen each channel to eight bits.
  always_comb begin
    red   = 8'd0;
    green = 8'd0;
    blue  = 8'd0;
    unique case (cfg.source_format)
      rfbpfc_pkg::SRC_PALETTE: begin
        red   = color[23:16];
        green = color[15:8];
        blue  = color[7:0];
      end
      rfbpfc_pkg::SRC_RGB565: begin
        red   = {source_pixel[15:11], 3'd0};
        green = {source_pixel[10:5], 2'd0};
        blue  = {source_pixel[4:0], 3'd0};
      end
      rfbpfc_pkg::SRC_XRGB8888: begin
        red   = source_pixel[23:16];
        green = source_pixel[15:8];
        blue  = source_pixel[7:0];
      end
      default: begin
        red   = 8'd0;
        green = 8'd0;
        blue  = 8'd0;
      end
    endcase
  end

  // Assemble the client pixel.
  assign pix = place_channel(red, cfg.red_width, cfg.red_position) |
               place_channel(green, cfg.green_width, cfg.green_position) |
               place_channel(blue, cfg.blue_width, cfg.blue_position);

  // Lay the bytes out for the wire, first byte in bits 7:0.
  always_comb begin
    if (raw32) begin
      word       = source_pixel;
      byte_count = 3'd4;
    end else if (raw16) begin
      word       = {16'd0, source_pixel[15:0]};
      byte_count = 3'd2;
    end else begin
      unique case (mode)
        rfbpfc_pkg::MODE_ONE_BYTE: begin
          word       = {24'd0, pix[7:0]};
          byte_count = 3'd1;
        end
        rfbpfc_pkg::MODE_TWO_NATIVE: begin
          word       = {16'd0, pix[15:0]};
          byte_count = 3'd2;
        end
        rfbpfc_pkg::MODE_TWO_SWAPPED: begin
          word       = {16'd0, pix[7:0], pix[15:8]};
          byte_count = 3'd2;
        end
        rfbpfc_pkg::MODE_FOUR_SWAPPED: begin
          word       = {pix[7:0], pix[15:8], pix[23:16], pix[31:24]};
          byte_count = 3'd4;
        end
        rfbpfc_pkg::MODE_THREE_BYTES: begin
          word       = {8'd0, pix[23:0]};
          byte_count = 3'd3;
        end
        default: begin
          word       = pix;
          byte_count = 3'd4;
        end
      endcase
    end
  end

endmodule

>>> design/rfb_pixel_format_converter.sv
// RFB pixel format converter, top level: input stage, palette, result register.
// Depends on rfbpfc_pkg, rfbpfc_cfg_regs, rfbpfc_palette and rfbpfc_convert.
//
// The converter takes one beat per clock while in_ready is high. A converted
// pixel passes stage one and then the result register: the edge that accepts
// its input beat latches the pixel and the registered palette read, and an
// edge with the result register free loads the assembled client bytes into it.
// A palette write beat (in_op high) updates the store and yields no result, as
// does a pixel while the screen format register holds the unused code. While
// out_ready is low a full result register holds; stage one still takes one more
// beat if it is empty and then holds too, so at most two pixels wait inside
// before in_ready falls. Registers on the cfg_ channel are always accepted
// and should only be written while no pixel is in flight. Palette entries
// are undefined until written; there is no clearing pass after reset.
module rfb_pixel_format_converter #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [31:0] in_source_pixel,
  input  logic [7:0]  in_entry_index,
  input  logic [23:0] in_entry_color,
  input  logic        in_last_in,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word,
  output logic [2:0]  out_byte_count,
  output logic        out_last,
  // Configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int PAL_AW = $clog2(PALETTE_DEPTH);

  rfbpfc_pkg::cfg_t cfg;

  logic        in_fire;
  logic        fmt_known;
  logic        keep;
  logic        wr_hit;
  logic        rd_hit;
  logic        advance_out;
  logic        s1_free;
  logic [23:0] pal_color;
  logic [31:0] conv_word;
  logic [2:0]  conv_count;

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [31:0] s1_pixel_r;
  logic        s1_last_r;
  logic        s1_hit_r;

  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] out_word_r;
  logic [2:0]  out_byte_count_r;
  logic        out_last_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  rfbpfc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Handshake: the result register frees when empty or taken, stage one
  // frees when empty or moving into the result register.
  assign advance_out = !out_valid_r || out_ready;
  assign s1_free     = !s1_valid_r || advance_out;
  assign in_ready    = s1_free;
  assign in_fire     = in_valid && in_ready;

  // Only pixel beats of a known screen format produce a result.
  assign fmt_known = (cfg.source_format == rfbpfc_pkg::SRC_PALETTE) ||
                     (cfg.source_format == rfbpfc_pkg::SRC_RGB565) ||
                     (cfg.source_format == rfbpfc_pkg::SRC_XRGB8888);
  assign keep      = !in_op && fmt_known;

  // Palette indexes beyond the store are ignored on write, black on read.
  assign wr_hit = {1'b0, in_entry_index} < 9'(PALETTE_DEPTH);
  assign rd_hit = {1'b0, in_source_pixel[7:0]} < 9'(PALETTE_DEPTH);

  rfbpfc_palette #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (PAL_AW)
  ) u_palette (
    .clk     (clk),
    .wr_en   (in_fire && in_op && wr_hit),
    .wr_addr (in_entry_index[PAL_AW-1:0]),
    .wr_data (in_entry_color),
    .rd_en   (in_fire && !in_op),
    .rd_addr (in_source_pixel[PAL_AW-1:0]),
    .rd_data (pal_color)
  );

  // Stage one: latch the pixel alongside the palette read.
  assign s1_valid_nxt = s1_free ? (in_fire && keep) : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !in_op) begin
      s1_pixel_r <= in_source_pixel;
      s1_last_r  <= in_last_in;
      s1_hit_r   <= rd_hit;
    end
  end

  // Conversion logic between stage one and the result register.
  rfbpfc_convert u_convert (
    .cfg           (cfg),
    .source_pixel  (s1_pixel_r),
    .palette_color (pal_color),
    .palette_hit   (s1_hit_r),
    .word          (conv_word),
    .byte_count    (conv_count)
  );

  // Result register.
  assign out_valid_nxt = advance_out ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_out && s1_valid_r) begin
      out_word_r       <= conv_word;
      out_byte_count_r <= conv_count;
      out_last_r       <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_word       = out_word_r;
  assign out_byte_count = out_byte_count_r;
  assign out_last       = out_last_r;

  // A pixel held in stage one is not lost while the result side stalls.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance_out |=> s1_valid_r)
    else $error("stage one dropped a stalled pixel");

  // A pixel leaving stage one always lands in the result register.
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && advance_out |=> out_valid_r)
    else $error("pixel lost between stage one and the result register");

  // Beats that produce no result never occupy stage one.
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !keep |=> !s1_valid_r)
    else $error("palette write or dropped pixel entered stage one");

  // A shown result always carries one to four bytes.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_byte_count_r != 3'd0) && (out_byte_count_r <= 3'd4))
    else $error("result byte count out of range");

endmodule
